// ===== sv/assert_macros.svh =====
// Assertion macros shared by the countdown timer RTL.
// Depends on nothing; files that assert include it by name.
// DCT_ASSERT expects clk and rst_n, DCT_ASSERT_ALWAYS expects clk, to be visible where used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked while out of reset.
`define DCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define DCT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define DCT_ASSERT(label, prop, msg)
`define DCT_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ===== sv/dct_pkg.sv =====
// Package for the debounced countdown timer: widths, codes, reset values, types.
// Depends on nothing; every module of the timer imports it.
package dct_pkg;

  localparam int MIN_W = 7;
  localparam int SEC_W = 6;
  localparam int OP_W = 2;
  localparam int PRESS_W = 4;
  localparam int CFG_DATA_W = 7;

  localparam int DEBOUNCE_COUNT_DEF = 2;

  // Operation codes carried by an input item.
  localparam logic [OP_W-1:0] OP_DEBOUNCE = 2'd0;
  localparam logic [OP_W-1:0] OP_SECOND = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_START_MINUTES = 1'b0;
  localparam logic CFG_START_SECONDS = 1'b1;

  localparam logic [MIN_W-1:0] START_MINUTES_RST = 7'd25;
  localparam logic [SEC_W-1:0] START_SECONDS_RST = 6'd0;
  localparam logic [SEC_W-1:0] SECONDS_WRAP = 6'd59;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_COUNTING = 2'd1,
    MODE_BUZZING = 2'd2
  } dct_mode_t;

  // Button events from the debouncer to the countdown.
  typedef struct packed {
    logic toggle;
  } dct_btn_t;

  // Next state of the countdown, as shown in a result item.
  typedef struct packed {
    dct_mode_t mode;
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
    logic expired;
  } dct_res_t;

endpackage

// ===== sv/dct_debounce.sv =====
// Button debouncer: press tick counter and release tracking.
// Depends on dct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dct_debounce #(
  parameter int DEBOUNCE_COUNT = dct_pkg::DEBOUNCE_COUNT_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            button_down,
  output dct_pkg::dct_btn_t btn
);
  import dct_pkg::*;

  logic [PRESS_W-1:0] press_ticks_r, press_ticks_nxt;
  logic               release_seen_r, release_seen_nxt;
  logic               held;

  assign held = !(press_ticks_r < PRESS_W'(DEBOUNCE_COUNT));

  always_comb begin
    press_ticks_nxt = press_ticks_r;
    release_seen_nxt = release_seen_r;
    btn = '0;
    if (step) begin
      if (button_down) begin
        if (!held) begin
          press_ticks_nxt = press_ticks_r + PRESS_W'(1);
        end else if (release_seen_r) begin
          btn.toggle = 1'b1;
          release_seen_nxt = 1'b0;
        end
      end else begin
        press_ticks_nxt = '0;
        release_seen_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r <= '0;
      release_seen_r <= 1'b1;
    end else begin
      press_ticks_r <= press_ticks_nxt;
      release_seen_r <= release_seen_nxt;
    end
  end

  `DCT_ASSERT(a_toggle_consumes_press, btn.toggle |=> !release_seen_r, "toggle left release set")
  `DCT_ASSERT(a_press_bounded,
    !(press_ticks_r > PRESS_W'(DEBOUNCE_COUNT)), "press count ran past debounce count")

endmodule

// ===== sv/dct_countdown.sv =====
// Countdown core: run mode and mm:ss counters, updated once per item.
// Depends on dct_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dct_countdown (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      advance,
  input  logic [dct_pkg::OP_W-1:0]  op,
  input  dct_pkg::dct_btn_t         btn,
  input  logic [dct_pkg::MIN_W-1:0] start_minutes,
  input  logic [dct_pkg::SEC_W-1:0] start_seconds,
  output dct_pkg::dct_res_t         res
);
  import dct_pkg::*;

  dct_mode_t          mode_r;
  logic [MIN_W-1:0]   min_r;
  logic [SEC_W-1:0]   sec_r;

  always_comb begin
    res.mode = mode_r;
    res.minutes = min_r;
    res.seconds = sec_r;
    res.expired = 1'b0;
    if (advance) begin
      unique case (op)
        OP_DEBOUNCE: begin
          if (btn.toggle) begin
            unique case (mode_r)
              MODE_IDLE:     res.mode = MODE_COUNTING;
              MODE_COUNTING: res.mode = MODE_IDLE;
              default:       res.mode = mode_r;
            endcase
          end
        end
        OP_SECOND: begin
          if (mode_r == MODE_IDLE) begin
            res.minutes = start_minutes;
            res.seconds = start_seconds;
          end else if (min_r == '0 && sec_r == '0) begin
            res.minutes = start_minutes;
            res.seconds = start_seconds;
            res.mode = MODE_BUZZING;
            res.expired = 1'b1;
          end else if (sec_r == '0) begin
            res.seconds = SECONDS_WRAP;
            if (min_r != '0) begin
              res.minutes = min_r - MIN_W'(1);
            end
          end else begin
            res.seconds = sec_r - SEC_W'(1);
          end
        end
        OP_STOP: res.mode = MODE_IDLE;
        default: res.mode = mode_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      min_r <= '0;
      sec_r <= '0;
    end else begin
      mode_r <= res.mode;
      min_r <= res.minutes;
      sec_r <= res.seconds;
    end
  end

  `DCT_ASSERT(a_hold_without_item, !advance |=> $stable(mode_r) && $stable(min_r)
    && $stable(sec_r), "countdown state changed without an item")
  `DCT_ASSERT(a_expired_buzzes, res.expired |=> mode_r == MODE_BUZZING,
    "expiry did not enter buzzing")
  `DCT_ASSERT(a_second_step, advance && op == OP_SECOND && mode_r != MODE_IDLE
    && sec_r != '0 |=> sec_r == $past(sec_r) - SEC_W'(1), "seconds did not step down")

endmodule

// ===== sv/debounced_countdown_timer_top.sv =====
// Top level of the debounced countdown timer: input and result registers,
// configuration registers, and the debouncer and countdown core.
// Depends on dct_pkg, dct_debounce, dct_countdown and assert_macros.svh.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------------------
//   in_     | in        | in_valid / in_stall | in_operation, in_button_down
//   out_    | out       | out_valid/out_stall | out_mode, out_minutes_left,
//           |           |                     | out_seconds_left, out_expired
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item is taken per cycle when the result side keeps up; each item gives
// exactly one result, which is registered first in the input register and
// then in the result register; a stall can hold it in either. The only logic
// between them is the debounce compare and small decrements and compares on
// the mm:ss counters. Reset (rst_n low, synchronous) empties both registers,
// sets the mode to idle, the counts to 00:00 and the start time to 25:00.
// When out_stall holds a result, the item in the input register waits and
// in_stall rises; the configuration port is always ready.
`include "assert_macros.svh"

module debounced_countdown_timer_top #(
  parameter int DEBOUNCE_COUNT = dct_pkg::DEBOUNCE_COUNT_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [dct_pkg::OP_W-1:0]       in_operation,
  input  logic                           in_button_down,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_mode,
  output logic [dct_pkg::MIN_W-1:0]      out_minutes_left,
  output logic [dct_pkg::SEC_W-1:0]      out_seconds_left,
  output logic                           out_expired,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [dct_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dct_pkg::*;

  // Input register: holds one accepted item until the result register frees.
  logic            in_vld_r, in_vld_nxt;
  logic [OP_W-1:0] in_op_r;
  logic            in_btn_r;

  // Result register.
  logic            out_vld_r, out_vld_nxt;
  dct_res_t        out_res_r;

  // Start time registers.
  logic [MIN_W-1:0] start_min_r;
  logic [SEC_W-1:0] start_sec_r;

  logic     advance;
  logic     in_accept;
  dct_btn_t btn;
  dct_res_t res;

  // The held item moves on when the result register is empty or being read.
  assign advance = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r && out_stall;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      start_min_r <= START_MINUTES_RST;
      start_sec_r <= START_SECONDS_RST;
    end else begin
      in_vld_r <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_START_MINUTES: start_min_r <= cfg_data[MIN_W-1:0];
          CFG_START_SECONDS: start_sec_r <= cfg_data[SEC_W-1:0];
          default:           start_min_r <= start_min_r;
        endcase
      end
    end
  end

  // Payload registers load without reset; their valid bits guard them.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_op_r <= in_operation;
      in_btn_r <= in_button_down;
    end
    if (advance) begin
      out_res_r <= res;
    end
  end

  dct_debounce #(
    .DEBOUNCE_COUNT(DEBOUNCE_COUNT)
  ) u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance && in_op_r == OP_DEBOUNCE),
    .button_down (in_btn_r),
    .btn         (btn)
  );

  dct_countdown u_countdown (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (advance),
    .op            (in_op_r),
    .btn           (btn),
    .start_minutes (start_min_r),
    .start_seconds (start_sec_r),
    .res           (res)
  );

  assign out_valid = out_vld_r;
  assign out_mode = out_res_r.mode;
  assign out_minutes_left = out_res_r.minutes;
  assign out_seconds_left = out_res_r.seconds;
  assign out_expired = out_res_r.expired;

  `DCT_ASSERT(a_held_item_waits, in_vld_r && !advance |=> in_vld_r,
    "held item dropped without a result")
  `DCT_ASSERT(a_result_follows, advance |=> out_vld_r, "item moved on without a result")

endmodule
